// ===== design/pidtc_pkg.sv =====
// Package for the clamped trapezoidal PID: widths, limits, control-word types
// and the microcode program. It has no dependencies. The sequencer and the top level use it.
`timescale 1ns / 1ps
`default_nettype none

package pidtc_pkg;

    localparam int SAMPLE_W = 16;   // Q8.8 measurement and setpoint
    localparam int COEF_W   = 32;   // Q16.16 coefficients
    localparam int ERR_W    = 17;   // measured - setpoint
    localparam int ESUM_W   = 18;   // error + last error
    localparam int ACC_W    = 48;   // Q24.24 integral
    localparam int SUM_W    = 50;   // P + I + D, Q26.24
    localparam int SHI_W    = SUM_W - 32;
    localparam int OPA_W    = 33;   // multiplier operand A
    localparam int PROD_W   = OPA_W + COEF_W;
    localparam int TAIL_W   = PROD_W - 32;
    localparam int Y_W      = SUM_W + 1;
    localparam int DRIVE_W  = 14;
    localparam int CFG_IDX_W = 2;
    localparam int STEP_W   = 3;

    localparam logic signed [DRIVE_W-1:0] DRIVE_MAX = 14'sd6144;
    localparam logic signed [DRIVE_W-1:0] DRIVE_MIN = -14'sd6144;
    localparam logic [COEF_W-1:0]         GAIN_RESET = 32'd65536;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PROP  = 2'd0,
        REG_INTEG = 2'd1,
        REG_DERIV = 2'd2,
        REG_GAIN  = 2'd3
    } t_reg_idx;

    typedef enum logic [2:0] {
        A_ERR  = 3'd0,
        A_ESUM = 3'd1,
        A_DM   = 3'd2,
        A_SLO  = 3'd3,
        A_SHI  = 3'd4
    } t_asel;

    typedef enum logic [1:0] {
        B_KP = 2'd0,
        B_KI = 2'd1,
        B_KD = 2'd2,
        B_KK = 2'd3
    } t_bsel;

    typedef enum logic [2:0] {
        OP_NONE       = 3'd0,
        OP_S_LOAD     = 3'd1,
        OP_INT_UPD    = 3'd2,
        OP_S_ADD_PROD = 3'd3,
        OP_S_ADD_INT  = 3'd4,
        OP_T_LOAD     = 3'd5,
        OP_FINISH     = 3'd6
    } t_op;

    typedef enum logic {
        J_NEXT = 1'b0,
        J_HOLD = 1'b1       // jump to target while the output register is occupied
    } t_jmp;

    typedef struct packed {
        logic              mul_en;
        t_asel             asel;
        t_bsel             bsel;
        t_op               op;
        t_jmp              jmp;
        logic [STEP_W-1:0] target;
        logic              last;
    } t_uword;

    typedef struct packed {
        logic   act;        // sequencer is running a sample
        t_uword word;
    } t_ctrl;

    // Microcode: one word per step. The product register carries each
    // multiply into the following step.
    function automatic t_uword ucode_rom(input logic [STEP_W-1:0] step);
        t_uword w;
        w = '{mul_en: 1'b0, asel: A_ERR, bsel: B_KP, op: OP_NONE,
              jmp: J_NEXT, target: '0, last: 1'b0};
        unique case (step)
            3'd0: begin
                w.mul_en = 1'b1; w.asel = A_ERR;  w.bsel = B_KP;
            end
            3'd1: begin
                w.mul_en = 1'b1; w.asel = A_ESUM; w.bsel = B_KI;
                w.op = OP_S_LOAD;
            end
            3'd2: begin
                w.mul_en = 1'b1; w.asel = A_DM;   w.bsel = B_KD;
                w.op = OP_INT_UPD;
            end
            3'd3: begin
                w.op = OP_S_ADD_PROD;
            end
            3'd4: begin
                w.op = OP_S_ADD_INT;
            end
            3'd5: begin
                w.mul_en = 1'b1; w.asel = A_SLO;  w.bsel = B_KK;
            end
            3'd6: begin
                w.mul_en = 1'b1; w.asel = A_SHI;  w.bsel = B_KK;
                w.op = OP_T_LOAD;
            end
            3'd7: begin
                w.op = OP_FINISH; w.jmp = J_HOLD; w.target = 3'd7;
                w.last = 1'b1;
            end
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ===== design/pidtc_seq.sv =====
// Microcode sequencer for the PID datapath: step counter, program table and jumps.
// It depends on pidtc_pkg, which holds the program and the control-word types.
`timescale 1ns / 1ps
`default_nettype none

module pidtc_seq (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_start,
    input  wire                 i_out_busy,
    output pidtc_pkg::t_ctrl    o_ctrl
);
    import pidtc_pkg::*;

    logic              r_busy, n_busy;
    logic [STEP_W-1:0] r_step, n_step;
    t_uword            w_word;

    assign w_word = ucode_rom(r_step);

    always_comb begin
        n_busy = r_busy;
        n_step = r_step;
        if (!r_busy) begin
            if (i_start) begin
                n_busy = 1'b1;
                n_step = '0;
            end
        end else if (w_word.jmp == J_HOLD && i_out_busy) begin
            n_step = w_word.target;
        end else if (w_word.last) begin
            n_busy = 1'b0;
            n_step = '0;
        end else begin
            n_step = r_step + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else begin
            r_busy <= n_busy;
            r_step <= n_step;
        end
    end

    assign o_ctrl = '{act: r_busy, word: w_word};

endmodule

`default_nettype wire

// ===== design/pid_trapezoid_clamped.sv =====
// Top level of the clamped trapezoidal PID controller: configuration registers,
// state, shared multiplier datapath and output register. Depends on pidtc_pkg and pidtc_seq.
`timescale 1ns / 1ps
`default_nettype none

// Each input transaction carries a measurement and a setpoint (Q8.8). The block
// forms error = measured - setpoint and sums a proportional term, a saturating
// trapezoidal integral (48-bit, Q24.24) and a derivative on the measurement. It
// then scales the sum by the overall gain, floors the result to Q8.8 and clamps
// it to +/-24.0; o_clamped flags a limited drive. One signed 33x32 multiplier is
// shared by all five products and is stepped by an eight-word microcode program.
// A sample therefore occupies the block for the whole program, during which
// o_in_ready is low; it rises again in the cycle after the last step, so a new
// sample is taken only once the program is through with the last one. The result
// lands in the output register at the final step, and the next sample is taken
// while that result waits. The final step holds only while the previous result
// has not yet left. Configuration writes are always accepted and must be made
// while no sample is in flight. Integral, previous error and previous measurement
// clear at reset.
module pid_trapezoid_clamped (
    input  wire                                     i_clk,
    input  wire                                     i_rst_n,
    // sample channel
    input  wire                                     i_in_valid,
    output logic                                    o_in_ready,
    input  wire  signed [pidtc_pkg::SAMPLE_W-1:0]   i_measured,
    input  wire  signed [pidtc_pkg::SAMPLE_W-1:0]   i_setpoint,
    // result channel
    output logic                                    o_out_valid,
    input  wire                                     i_out_ready,
    output logic signed [pidtc_pkg::DRIVE_W-1:0]    o_drive,
    output logic                                    o_clamped,
    // configuration channel
    input  wire                                     i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire         [pidtc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire         [pidtc_pkg::COEF_W-1:0]     i_cfg_data
);
    import pidtc_pkg::*;

    // coefficient registers
    logic signed [COEF_W-1:0] r_kp, r_ki, r_kd, r_kk;

    // controller state
    logic signed [ACC_W-1:0]    r_integ, n_integ;
    logic signed [ERR_W-1:0]    r_last_err;
    logic signed [SAMPLE_W-1:0] r_last_meas;

    // per-sample operands and working registers
    logic signed [ERR_W-1:0]  r_err;
    logic signed [ESUM_W-1:0] r_esum;
    logic signed [ERR_W-1:0]  r_dm;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [SUM_W-1:0]  r_s;
    logic signed [TAIL_W-1:0] r_t;

    // output register
    logic                      r_out_valid;
    logic signed [DRIVE_W-1:0] r_drive, n_drive;
    logic                      r_clamped, n_clamped;

    t_ctrl                     w_ctrl;
    logic                      w_in_acc, w_out_busy, w_finish;
    logic signed [ERR_W-1:0]   w_err;
    logic signed [OPA_W-1:0]   w_opa;
    logic signed [COEF_W-1:0]  w_opb;
    logic signed [SUM_W-1:0]   w_isum;
    logic signed [Y_W-1:0]     w_y;

    assign o_in_ready  = !w_ctrl.act;
    assign o_cfg_ready = 1'b1;
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_out_busy  = r_out_valid && !i_out_ready;
    assign w_finish    = w_ctrl.act && w_ctrl.word.op == OP_FINISH && !w_out_busy;

    pidtc_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_in_acc),
        .i_out_busy (w_out_busy),
        .o_ctrl     (w_ctrl)
    );

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp <= '0;
            r_ki <= '0;
            r_kd <= '0;
            r_kk <= GAIN_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_PROP:  r_kp <= i_cfg_data;
                REG_INTEG: r_ki <= i_cfg_data;
                REG_DERIV: r_kd <= i_cfg_data;
                REG_GAIN:  r_kk <= i_cfg_data;
            endcase
        end
    end

    // capture the sample: form the error, the error sum and the measurement difference and advance history
    assign w_err = ERR_W'(i_measured) - ERR_W'(i_setpoint);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_err  <= '0;
            r_last_meas <= '0;
        end else if (w_in_acc) begin
            r_last_err  <= w_err;
            r_last_meas <= i_measured;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_err  <= w_err;
            r_esum <= ESUM_W'(w_err) + ESUM_W'(r_last_err);
            r_dm   <= ERR_W'(i_measured) - ERR_W'(r_last_meas);
        end
    end

    // operand selection for the shared multiplier
    always_comb begin
        unique case (w_ctrl.word.asel)
            A_ERR:   w_opa = OPA_W'(r_err);
            A_ESUM:  w_opa = OPA_W'(r_esum);
            A_DM:    w_opa = OPA_W'(r_dm);
            A_SLO:   w_opa = $signed({1'b0, r_s[31:0]});
            A_SHI:   w_opa = OPA_W'($signed(r_s[SUM_W-1:32]));
            default: w_opa = '0;
        endcase
        unique case (w_ctrl.word.bsel)
            B_KP: w_opb = r_kp;
            B_KI: w_opb = r_ki;
            B_KD: w_opb = r_kd;
            B_KK: w_opb = r_kk;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_ctrl.act && w_ctrl.word.mul_en)
            r_prod <= PROD_W'(w_opa) * PROD_W'(w_opb);
    end

    // integral update, saturated to 48 bits
    assign w_isum = SUM_W'(r_integ) + r_prod[SUM_W-1:0];

    always_comb begin
        n_integ = w_isum[ACC_W-1:0];
        if (w_isum[SUM_W-1:ACC_W-1] != {(SUM_W-ACC_W+1){w_isum[SUM_W-1]}})
            n_integ = w_isum[SUM_W-1] ? {1'b1, {(ACC_W-1){1'b0}}}
                                      : {1'b0, {(ACC_W-1){1'b1}}};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_integ <= '0;
        else if (w_ctrl.act && w_ctrl.word.op == OP_INT_UPD)
            r_integ <= n_integ;
    end

    // sum register and the upper part of the gain product
    always_ff @(posedge i_clk) begin
        if (w_ctrl.act) begin
            unique case (w_ctrl.word.op)
                OP_S_LOAD:     r_s <= r_prod[SUM_W-1:0];
                OP_S_ADD_PROD: r_s <= r_s + r_prod[SUM_W-1:0];
                OP_S_ADD_INT:  r_s <= r_s + SUM_W'(r_integ);
                OP_T_LOAD:     r_t <= r_prod[PROD_W-1:32];
                default: ;
            endcase
        end
    end

    // floor(S * gain / 2^32) = high(S) * gain + floor(low(S) * gain / 2^32)
    assign w_y = Y_W'($signed(r_prod[SUM_W-1:0])) + Y_W'(r_t);

    always_comb begin
        n_drive   = w_y[DRIVE_W-1:0];
        n_clamped = 1'b0;
        priority if (w_y > Y_W'(DRIVE_MAX)) begin
            n_drive   = DRIVE_MAX;
            n_clamped = 1'b1;
        end else if (w_y < Y_W'(DRIVE_MIN)) begin
            n_drive   = DRIVE_MIN;
            n_clamped = 1'b1;
        end
    end

    // output register: hold until the transaction is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_out_valid <= 1'b0;
        else if (w_finish)
            r_out_valid <= 1'b1;
        else if (i_out_ready)
            r_out_valid <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (w_finish) begin
            r_drive   <= n_drive;
            r_clamped <= n_clamped;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_drive     = r_drive;
    assign o_clamped   = r_clamped;

    function automatic logic u_seq_started(input t_ctrl c);
        return c.act && c.word.op == OP_NONE && c.word.mul_en;
    endfunction

    // a flagged result sits exactly on a limit
    a_clamp_on_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_clamped |-> (o_drive == DRIVE_MAX || o_drive == DRIVE_MIN))
        else $error("clamped result not on a limit");

    // drive never leaves the +/-24 band
    a_drive_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_drive <= DRIVE_MAX && o_drive >= DRIVE_MIN))
        else $error("drive outside limits");

    // an accepted sample starts the program and closes the input
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (!o_in_ready && u_seq_started(w_ctrl)))
        else $error("sample accepted but sequencer idle");

    // a result is only loaded while the previous one is gone or leaving
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_finish |-> (!r_out_valid || i_out_ready))
        else $error("result overwritten");

endmodule

`default_nettype wire

// ===== sim/pid_trapezoid_clamped_tb.sv =====
// Self-checking testbench for pid_trapezoid_clamped: a bit-accurate drive predictor
// in a scoreboard class, handshake driver tasks, random stalls and a watchdog.
// Depends on pidtc_pkg and the pid_trapezoid_clamped RTL only.
`timescale 1ns / 1ps

module pid_trapezoid_clamped_tb;
    import pidtc_pkg::*;

    localparam int     RESET_CYCLES   = 11;
    localparam int     WATCHDOG_LIMIT = 2000;  // idle cycles
    localparam int     REPORT_LIMIT   = 10;
    localparam int     PHASES         = 7;
    localparam int     PHASE_ITEMS    = 250;
    localparam int     SETTLE_CYCLES  = 18;    // settling margin after the last drive
    localparam longint ACC_HI         = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint ACC_LO         = -ACC_HI - 1;

    typedef struct packed {
        logic signed [DRIVE_W-1:0] drive;
        logic                      clamped;
    } t_drive_result;

    // Predicts the drive of each accepted sample and checks results in order.
    class pid_drive_model;
        logic signed [COEF_W-1:0]   kp, ki, kd, kk;
        logic signed [ACC_W-1:0]    integ;
        logic signed [ERR_W-1:0]    prev_err;
        logic signed [SAMPLE_W-1:0] prev_meas;
        t_drive_result              pending_drives[$];
        int                         faults;

        function new();
            kp        = '0;
            ki        = '0;
            kd        = '0;
            kk        = GAIN_RESET;
            integ     = '0;
            prev_err  = '0;
            prev_meas = '0;
            faults    = 0;
        endfunction

        function void set_reg(t_reg_idx idx, logic [COEF_W-1:0] value);
            case (idx)
                REG_PROP:  kp = value;
                REG_INTEG: ki = value;
                REG_DERIV: kd = value;
                REG_GAIN:  kk = value;
                default: ;
            endcase
        endfunction

        function void add_sample(logic signed [SAMPLE_W-1:0] meas,
                                 logic signed [SAMPLE_W-1:0] setp);
            logic signed [ERR_W-1:0] err;
            logic signed [ERR_W-1:0] dmeas;
            longint                  p, d, s, acc, q;
            logic signed [95:0]      s_wide, k_wide, scaled;
            t_drive_result           r;
            err   = meas - setp;
            dmeas = meas - prev_meas;
            p     = longint'(kp) * longint'(err);
            // trapezoid: the halving lives in the coefficient
            acc = longint'(integ) + longint'(ki) * (longint'(err) + longint'(prev_err));
            if (acc > ACC_HI)
                acc = ACC_HI;
            else if (acc < ACC_LO)
                acc = ACC_LO;
            integ = acc[ACC_W-1:0];
            d     = longint'(kd) * longint'(dmeas);
            s     = p + acc + d;
            // exact product, arithmetic shift floors towards minus infinity
            s_wide = s;
            k_wide = kk;
            scaled = (s_wide * k_wide) >>> 32;
            q      = scaled[63:0];
            r.clamped = 1'b1;
            if (q > longint'(DRIVE_MAX)) begin
                r.drive = DRIVE_MAX;
            end else if (q < longint'(DRIVE_MIN)) begin
                r.drive = DRIVE_MIN;
            end else begin
                r.drive   = q[DRIVE_W-1:0];
                r.clamped = 1'b0;
            end
            prev_err  = err;
            prev_meas = meas;
            pending_drives.push_back(r);
        endfunction

        function void check_drive(logic signed [DRIVE_W-1:0] drive, logic clamped);
            t_drive_result want;
            if (pending_drives.size() == 0) begin
                faults++;
                if (faults <= REPORT_LIMIT)
                    $display("unexpected result: drive %0d clamped %0b, nothing pending",
                             drive, clamped);
            end else begin
                want = pending_drives.pop_front();
                if (drive !== want.drive || clamped !== want.clamped) begin
                    faults++;
                    if (faults <= REPORT_LIMIT)
                        $display("result mismatch: drive %0d clamped %0b, expected %0d / %0b",
                                 drive, clamped, want.drive, want.clamped);
                end
            end
        endfunction
    endclass

    logic                       i_clk       = 1'b0;
    logic                       i_rst_n     = 1'b0;
    logic                       i_in_valid  = 1'b0;
    logic signed [SAMPLE_W-1:0] i_measured  = '0;
    logic signed [SAMPLE_W-1:0] i_setpoint  = '0;
    logic                       i_out_ready = 1'b0;
    logic                       i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]       i_cfg_index = '0;
    logic [COEF_W-1:0]          i_cfg_data  = '0;
    wire                        o_in_ready;
    wire                        o_out_valid;
    wire signed [DRIVE_W-1:0]   o_drive;
    wire                        o_clamped;
    wire                        o_cfg_ready;

    pid_drive_model             model;
    bit                         steady      = 1'b0;  // no idling on either side
    int                         stall_left  = 0;
    int                         quiet_cycles = 0;
    logic signed [SAMPLE_W-1:0] last_meas   = '0;

    pid_trapezoid_clamped DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_measured  (i_measured),
        .i_setpoint  (i_setpoint),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_drive     (o_drive),
        .o_clamped   (o_clamped),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Result side: check every accepted transaction, then decide the next ready.
    // Most stalls are short; one in ten is long enough to back up the output register.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            model.check_drive(o_drive, o_clamped);
        if (stall_left > 0) begin
            stall_left  <= stall_left - 1;
            i_out_ready <= 1'b0;
        end else if (!steady && $urandom_range(99) < 2) begin
            stall_left  <= ($urandom_range(9) == 0) ? $urandom_range(10, 30)
                                                     : $urandom_range(0, 3);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Watchdog: end the run if no channel moves a transaction for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL pid_trapezoid_clamped");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic int sym_rand(int half);
        return int'($urandom_range(2 * half, 0)) - half;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] corner_value();
        case ($urandom_range(4))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2:       return 16'sh0000;
            3:       return 16'shFFFF;
            default: return 16'sh0001;
        endcase
    endfunction

    // Hold the write until accepted; the caller drops valid after the last one.
    task automatic write_reg(input t_reg_idx idx, input logic [COEF_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        model.set_reg(idx, value);
    endtask

    task automatic load_gains(input logic [COEF_W-1:0] kp, input logic [COEF_W-1:0] ki,
                              input logic [COEF_W-1:0] kd, input logic [COEF_W-1:0] kk);
        write_reg(REG_PROP, kp);
        write_reg(REG_INTEG, ki);
        write_reg(REG_DERIV, kd);
        write_reg(REG_GAIN, kk);
        i_cfg_valid <= 1'b0;
    endtask

    // Optionally idle first, then hold the sample until the block takes it.
    task automatic send_sample(input logic signed [SAMPLE_W-1:0] meas,
                               input logic signed [SAMPLE_W-1:0] setp);
        if (!steady && $urandom_range(99) < 8) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_measured <= meas;
        i_setpoint <= setp;
        do @(posedge i_clk); while (!o_in_ready);
        model.add_sample(meas, setp);
        last_meas = meas;
    endtask

    // Drop valid, wait for every pending drive, then let the pipeline settle.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (model.pending_drives.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        logic signed [SAMPLE_W-1:0] meas, setp;
        logic [COEF_W-1:0]          kp, ki, kd, kk;
        model = new();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Unity P, half D on the measurement, no integral: drive equals the error
        // whenever the measurement repeats, so the limits can be hit exactly.
        load_gains(32'h0001_0000, 32'h0000_0000, 32'h0000_8000, 32'h0001_0000);
        send_sample(16'sd512, 16'sd0);       // first sample: history still zero
        send_sample(16'sd6144, 16'sd0);
        send_sample(16'sd6144, 16'sd0);      // exactly +24.0, not flagged
        send_sample(16'sd6144, -16'sd1);     // just above, clamped
        send_sample(-16'sd6144, 16'sd0);
        send_sample(-16'sd6144, 16'sd0);     // exactly -24.0, not flagged
        send_sample(-16'sd6144, 16'sd1);     // just below, clamped
        send_sample(16'sd1, 16'sd0);
        send_sample(16'sd0, 16'sd0);         // -0.5 LSB floors to -1
        send_sample(16'sh7FFF, 16'sh8000);
        send_sample(16'sh8000, 16'sh7FFF);
        send_sample(16'sh7FFF, 16'sh7FFF);
        send_sample(16'sh8000, 16'sh8000);
        wait_drained();

        // Integral only, extreme coefficients: saturate high, then low.
        load_gains(32'h0000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'h8000_0000);
        send_sample(16'sh7FFF, 16'sh8000);
        send_sample(16'sh7FFF, 16'sh8000);   // saturates at the top
        send_sample(16'sh8000, 16'sh7FFF);
        send_sample(16'sh8000, 16'sh7FFF);   // drops to just above the bottom rail
        send_sample(16'sh8000, 16'sd0);
        wait_drained();
        // Unwind: -2^31 * -65536 lifts the bottom rail back to exactly zero.
        write_reg(REG_INTEG, 32'h8000_0000);
        i_cfg_valid <= 1'b0;
        send_sample(16'sh8000, 16'sd0);
        wait_drained();

        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: begin
                    kp = sym_rand(4);    ki = '0;
                    kd = sym_rand(4);    kk = 32'h7FFF_FFFF;
                end
                1: begin
                    kp = sym_rand(1 << 18); ki = sym_rand(1 << 10);
                    kd = sym_rand(1 << 17); kk = 32'h0001_0000;
                end
                2: begin
                    kp = 32'h7FFF_FFFF;  ki = '0;
                    kd = 32'h8000_0000;  kk = 32'h0000_0001;
                end
                3: begin
                    kp = sym_rand(1 << 17); ki = sym_rand(1 << 8);
                    kd = sym_rand(1 << 16); kk = sym_rand(1 << 18);
                end
                4: begin
                    kp = $urandom;       ki = sym_rand(1 << 6);
                    kd = $urandom;       kk = '0;
                end
                5: begin
                    kp = $urandom;       ki = sym_rand(1 << 10);
                    kd = $urandom;       kk = $urandom;
                end
                default: begin
                    kp = 32'hFFFF_0000;  ki = sym_rand(1 << 10);
                    kd = 32'h7FFF_FFFF;  kk = 32'h8000_0000;
                end
            endcase
            load_gains(kp, ki, kd, kk);
            steady <= (phase == 3);

            repeat (PHASE_ITEMS) begin
                case ($urandom_range(9))
                    6: begin
                        meas = $urandom;
                        setp = $urandom;
                    end
                    7: begin                 // repeat measurement: no derivative kick
                        meas = last_meas;
                        setp = sym_rand(1024);
                    end
                    8: begin                 // error close to the drive limit
                        meas = sym_rand(8192);
                        setp = meas - sym_rand(6400);
                    end
                    9: begin
                        meas = corner_value();
                        setp = corner_value();
                    end
                    default: begin
                        meas = sym_rand(1024);
                        setp = sym_rand(1024);
                    end
                endcase
                send_sample(meas, setp);
            end
            wait_drained();
        end

        if (model.faults == 0 && model.pending_drives.size() == 0)
            $display("PASS pid_trapezoid_clamped");
        else
            $display("FAIL pid_trapezoid_clamped");
        $finish;
    end

endmodule

// ===== sim.f =====
design/pidtc_pkg.sv
design/pidtc_seq.sv
design/pid_trapezoid_clamped.sv
sim/pid_trapezoid_clamped_tb.sv
